// File: src/assert_macros.svh
// assertion macros shared by the action slot pool rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define ASP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/asp_pkg.sv
// shared types, codes and widths for the action slot pool
// no dependencies; imported by every other file of the block but assert_macros.svh
package asp_pkg;

  localparam int MODE_W        = 3;
  localparam int SLOT_W        = 5;
  localparam int TYPE_W        = 4;
  localparam int PEND_W        = 6;
  localparam int ST_W          = 3;
  localparam int NUM_SLOTS_DEF = 32;

  // queue between front and back, depth must be a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  // request mode codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DONE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FAILED = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ABORT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

  // slot lifecycle codes as stored in the slot memory
  typedef enum logic [ST_W-1:0] {
    ST_FREE      = 3'd0,
    ST_REQUESTED = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_DONE      = 3'd3,
    ST_FAILED    = 3'd4,
    ST_ABORTED   = 3'd5
  } slot_st_t;

  // command class decided by the front
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_SET,
    CMD_QUERY,
    CMD_RANGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    slot_st_t           new_st;
    logic [SLOT_W-1:0]  idx;
    logic [TYPE_W-1:0]  act_type;
  } cmd_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

endpackage

// File: src/asp_ifs.sv
// valid/ready channel interfaces for requests and results
// depends on asp_pkg for field widths
interface asp_in_if import asp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot_index;
  logic [TYPE_W-1:0] action_type;

  modport source (output valid, output mode, output slot_index, output action_type,
                  input ready);
  modport sink   (input valid, input mode, input slot_index, input action_type,
                  output ready);
endinterface

interface asp_out_if import asp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [SLOT_W-1:0] slot_out;
  logic              has_run;
  logic [TYPE_W-1:0] slot_type;
  logic [PEND_W-1:0] pending_count;

  modport source (output valid, output granted, output slot_out, output has_run,
                  output slot_type, output pending_count, input ready);
  modport sink   (input valid, input granted, input slot_out, input has_run,
                  input slot_type, input pending_count, output ready);
endinterface

// File: src/asp_front.sv
// request front: accepts request words and classifies them into commands
// depends on asp_pkg and asp_in_if
module asp_front import asp_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  asp_in_if.sink    in_ch,
  input  q_stat_t   q_stat,
  output logic      q_push,
  output cmd_t      q_data
);

  logic in_range;

  assign in_ch.ready = q_stat.not_full;
  assign q_push      = in_ch.valid && q_stat.not_full;
  assign in_range    = int'(in_ch.slot_index) < NUM_SLOTS;

  always_comb begin
    q_data.idx      = in_ch.slot_index;
    q_data.act_type = in_ch.action_type;
    q_data.new_st   = ST_FREE;
    q_data.kind     = CMD_QUERY;
    unique case (in_ch.mode)
      MODE_ADD:    q_data.kind = CMD_ADD;
      MODE_DONE: begin
        q_data.kind   = CMD_SET;
        q_data.new_st = ST_DONE;
      end
      MODE_FAILED: begin
        q_data.kind   = CMD_SET;
        q_data.new_st = ST_FAILED;
      end
      MODE_ABORT: begin
        q_data.kind   = CMD_SET;
        q_data.new_st = ST_ABORTED;
      end
      MODE_REMOVE: begin
        q_data.kind   = CMD_SET;
        q_data.new_st = ST_FREE;
      end
      default:     q_data.kind = CMD_QUERY;  // query and unused codes
    endcase
    // addressed command outside the pool touches nothing
    if (q_data.kind != CMD_ADD && !in_range) begin
      q_data.kind = CMD_RANGE;
    end
  end

endmodule

// File: src/asp_fifo.sv
// short command queue between the request front and the slot engine
// depends on asp_pkg
module asp_fifo import asp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    wr_data,
  input  logic    pop,
  output cmd_t    rd_data,
  output q_stat_t stat
);

  cmd_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign rd_data        = ent_r[rd_ptr_r];
  assign stat.not_full  = cnt_r != (Q_PTR_W + 1)'(Q_DEPTH);
  assign stat.not_empty = cnt_r != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: src/asp_back.sv
// slot engine: slot memory, serial scan for add, state update and result register
// depends on asp_pkg, asp_out_if and assert_macros.svh
`include "assert_macros.svh"

module asp_back import asp_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_head,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  asp_out_if.source out_ch
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = ST_W + TYPE_W;
  localparam int SAT_W = CNT_W + PEND_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RDWAIT,
    S_FIN
  } bstate_t;

  bstate_t state_r, state_nxt;
  cmd_t    cmd_r;

  // slot memory, entry = {state, type}; never-written entries read as free
  logic [ENT_W-1:0]     mem [NUM_SLOTS];
  logic [ENT_W-1:0]     rd_data_r;
  logic [NUM_SLOTS-1:0] valid_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;

  // scan pipeline
  logic [IDX_W-1:0] scan_addr_r;
  logic             rd_live_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             found_free_r, found_done_r;
  logic [IDX_W-1:0] free_idx_r, done_idx_r;

  // pending update staged for the final cycle
  logic              fin_we_r;
  logic [IDX_W-1:0]  fin_idx_r;
  slot_st_t          fin_st_r;
  logic [TYPE_W-1:0] fin_kind_r;
  logic              fin_granted_r;
  logic [SLOT_W-1:0] fin_slot_r;
  logic              fin_run_r;
  logic [TYPE_W-1:0] fin_type_r;
  logic              fin_inc_r, fin_dec_r;

  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [SAT_W-1:0]  pend_wide;
  logic [PEND_W-1:0] pend_sat;

  logic              out_valid_r;
  logic              out_granted_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_run_r;
  logic [TYPE_W-1:0] out_type_r;
  logic [PEND_W-1:0] out_pend_r;
  logic              out_free;

  slot_st_t          old_st, new_st;
  logic [TYPE_W-1:0] old_kind;
  logic              cur_reuse, cur_done;
  logic              free_any, done_any, pick_any;
  logic [IDX_W-1:0]  free_pick, done_pick, pick;
  logic              old_pend, new_pend;

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && q_stat.not_empty;
  assign mem_we   = (state_r == S_FIN) && out_free && fin_we_r;
  assign rd_addr  = (state_r == S_SCAN) ? scan_addr_r : IDX_W'(q_head.idx);

  // decode of the entry read last cycle
  always_comb begin
    old_st    = rd_vld_r ? slot_st_t'(rd_data_r[ENT_W-1 -: ST_W]) : ST_FREE;
    old_kind  = rd_vld_r ? rd_data_r[TYPE_W-1:0] : '0;
    cur_reuse = rd_live_r &&
                (old_st == ST_FREE || old_st == ST_ABORTED || old_st == ST_FAILED);
    cur_done  = rd_live_r && (old_st == ST_DONE);
    free_any  = found_free_r || cur_reuse;
    done_any  = found_done_r || cur_done;
    free_pick = found_free_r ? free_idx_r : rd_idx_r;
    done_pick = found_done_r ? done_idx_r : rd_idx_r;
    pick_any  = free_any || done_any;
    pick      = free_any ? free_pick : done_pick;
    new_st    = (cmd_r.kind == CMD_SET) ? cmd_r.new_st : old_st;
    old_pend  = (old_st == ST_REQUESTED) || (old_st == ST_RUNNING);
    new_pend  = (new_st == ST_REQUESTED) || (new_st == ST_RUNNING);
  end

  always_comb begin
    pend_nxt = pend_r + CNT_W'(fin_inc_r) - CNT_W'(fin_dec_r);
    pend_wide = SAT_W'(pend_nxt);
    pend_sat  = (pend_wide > SAT_W'(PEND_MAX)) ? PEND_MAX : pend_wide[PEND_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_head.kind) inside
            CMD_ADD:             state_nxt = S_SCAN;
            CMD_SET, CMD_QUERY:  state_nxt = S_RDWAIT;
            default:             state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN:   if (scan_addr_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FIN;
      S_RDWAIT: state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fin_idx_r] <= {fin_st_r, fin_kind_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_live_r   <= 1'b0;
      valid_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_live_r <= (state_r == S_SCAN);
      rd_idx_r  <= scan_addr_r;
      rd_vld_r  <= valid_r[rd_addr];

      if (rd_live_r) begin
        if (cur_reuse && !found_free_r) begin
          found_free_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
        end
        if (cur_done && !found_done_r) begin
          found_done_r <= 1'b1;
          done_idx_r   <= rd_idx_r;
        end
      end

      // drained word clears the register unless the commit step reloads it
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r        <= q_head;
            scan_addr_r  <= '0;
            found_free_r <= 1'b0;
            found_done_r <= 1'b0;
            // out-of-pool address reports its own index with zero flags and type, and changes nothing
            fin_we_r      <= 1'b0;
            fin_granted_r <= 1'b0;
            fin_slot_r    <= q_head.idx;
            fin_run_r     <= 1'b0;
            fin_type_r    <= '0;
            fin_inc_r     <= 1'b0;
            fin_dec_r     <= 1'b0;
          end
        end
        S_SCAN: begin
          scan_addr_r <= scan_addr_r + 1'b1;
        end
        S_DRAIN: begin
          fin_we_r      <= pick_any;
          fin_idx_r     <= pick;
          fin_st_r      <= ST_REQUESTED;
          fin_kind_r    <= cmd_r.act_type;
          fin_granted_r <= pick_any;
          fin_slot_r    <= pick_any ? SLOT_W'(pick) : '0;
          fin_run_r     <= 1'b0;
          fin_type_r    <= pick_any ? cmd_r.act_type : '0;
          fin_inc_r     <= pick_any;
          fin_dec_r     <= 1'b0;
        end
        S_RDWAIT: begin
          fin_we_r      <= (cmd_r.kind == CMD_SET);
          fin_idx_r     <= IDX_W'(cmd_r.idx);
          fin_st_r      <= new_st;
          fin_kind_r    <= old_kind;
          fin_granted_r <= 1'b0;
          fin_slot_r    <= cmd_r.idx;
          fin_run_r     <= (new_st == ST_DONE) || (new_st == ST_FAILED);
          fin_type_r    <= old_kind;
          fin_inc_r     <= !old_pend && new_pend;
          fin_dec_r     <= old_pend && !new_pend;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_granted_r <= fin_granted_r;
            out_slot_r    <= fin_slot_r;
            out_run_r     <= fin_run_r;
            out_type_r    <= fin_type_r;
            out_pend_r    <= pend_sat;
            pend_r        <= pend_nxt;
            if (fin_we_r) begin
              valid_r[fin_idx_r] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted       = out_granted_r;
  assign out_ch.slot_out      = out_slot_r;
  assign out_ch.has_run       = out_run_r;
  assign out_ch.slot_type     = out_type_r;
  assign out_ch.pending_count = out_pend_r;

  `ASP_ASSERT(a_pend_bound, clk, rst_n, pend_r <= CNT_W'(NUM_SLOTS), "pending count above pool size")
  `ASP_ASSERT(a_we_in_fin, clk, rst_n, mem_we |-> (state_r == S_FIN), "slot write outside final step")
  `ASP_ASSERT_NEXT(a_out_load, clk, rst_n, (state_r == S_FIN) && out_free, out_valid_r, "result not loaded")
  `ASP_ASSERT_NEXT(a_pend_hold, clk, rst_n, state_r != S_FIN, $stable(pend_r), "pending count moved early")
  `ASP_ASSERT(a_grant_claim, clk, rst_n, ((state_r == S_FIN) && fin_granted_r) |-> (fin_we_r && fin_inc_r && (fin_st_r == ST_REQUESTED)), "grant without claim")

endmodule

// File: src/action_slot_pool_top.sv
// top level of the action slot pool: request front, command queue, slot engine
// depends on asp_pkg, asp_in_if, asp_out_if, asp_front, asp_fifo, asp_back
//
//  channel  dir  handshake                payload
//  in_ch    in   valid/ready, sink        mode, slot_index, action_type
//  out_ch   out  valid/ready, source      granted, slot_out, has_run, slot_type,
//                                         pending_count
//
// an add word reads one slot memory entry per cycle over the whole pool in the engine,
//   then a drain step picks the slot and a commit step writes it
// addressed words (mark, remove, query) go through the engine steps read, update and commit
// a two-word queue lets new words be accepted while the engine is busy
// reset: synchronous active-low rst_n; all slots read as free with type zero at once
// a stalled out_ch holds the engine in its commit step; the queue keeps filling
module action_slot_pool_top import asp_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  asp_in_if.sink    in_ch,
  asp_out_if.source out_ch
);

  // front to queue
  logic    q_push;
  cmd_t    q_data;
  // queue to engine
  logic    q_pop;
  cmd_t    q_head;
  q_stat_t q_stat;

  // classify the incoming word; out-of-pool addresses are flagged here
  asp_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_data)
  );

  // decouples acceptance from the serial slot work
  asp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_data),
    .pop     (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  // slot memory, lowest-slot scan, pending counter and result register
  asp_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
